@@ sv/lcq_pkg.sv @@
// Shared constants, types and register indexes of the contour level quantizer.
package lcq_pkg;

  // Field and register widths
  localparam int SAMPLE_W   = 32;
  localparam int LEVEL_W    = 8;
  localparam int MIN_W      = 31;
  localparam int RATIO_W    = 25;
  localparam int COUNT_W    = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 31;

  // Number of levels and fixed-point format; a sample spans two fraction-sized words
  localparam int MAX_LEVELS = 64;
  localparam int FRAC_BITS  = 16;
  localparam int WORD_W     = FRAC_BITS;

  // Threshold arithmetic
  localparam int THR_W     = 2 * WORD_W + 1;
  localparam int PROD_W    = WORD_W + RATIO_W;
  localparam int CARRY_W   = PROD_W - WORD_W;
  localparam int MEM_DEPTH = MAX_LEVELS + 2;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int IDX_W     = $clog2(MAX_LEVELS);
  localparam int LIM_W     = $clog2(MAX_LEVELS + 1);

  // Smallest accepted ratio: value * 1000 must exceed 1001 * 2^FRAC_BITS
  localparam int RATIO_MIN = ((1001 << FRAC_BITS) / 1000) + 1;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_LEVEL   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_RATIO = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_COUNT = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SIGNED_MODE = 2'd3;

  // Register reset values
  localparam logic [MIN_W-1:0]   MIN_LEVEL_RST   = MIN_W'(65536);
  localparam logic [RATIO_W-1:0] LEVEL_RATIO_RST = RATIO_W'(131072);
  localparam logic [COUNT_W-1:0] LEVEL_COUNT_RST = COUNT_W'(16);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [THR_W-1:0]  thr_t;

  // Status of the threshold generator
  typedef struct packed {
    logic             busy;
    logic [LIM_W-1:0] nfin;
  } gen_sts_t;

endpackage

@@ sv/lcq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lcq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, register one read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/lcq_thr_gen.sv @@
// Threshold generator: exact geometric thresholds by word-serial multiplication.
module lcq_thr_gen
  import lcq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   restart,
  input  logic [MIN_W-1:0]       min_level,
  input  logic [RATIO_W-1:0]     level_ratio,
  output thr_t [MAX_LEVELS-1:0]  thr,
  output gen_sts_t               sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_PASS = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]         st_r, st_nxt;
  logic [IDX_W-1:0]   n_r, n_nxt;
  logic [MEM_AW-1:0]  i_r, i_nxt;
  logic               pv_r, pv_nxt;
  logic [MEM_AW-1:0]  pi_r, pi_nxt;
  logic [CARRY_W-1:0] carry_r, carry_nxt;
  logic               sticky_r, sticky_nxt;
  word_t              lo_r, lo_nxt;
  word_t              hi_r, hi_nxt;
  logic [LIM_W-1:0]   nfin_r, nfin_nxt;
  thr_t [MAX_LEVELS-1:0] thr_r;

  logic [MEM_AW-1:0]  n_ext;
  logic [MEM_AW-1:0]  last_idx;
  logic [CARRY_W-1:0] carry_in;
  word_t              rd_data;
  word_t              old_w;
  word_t              new_w;
  logic [PROD_W-1:0]  prod;
  thr_t               thr_val;
  logic               ovf;
  logic               thr_we;
  logic [IDX_W-1:0]   thr_wa;
  thr_t               thr_wd;

  // Hold the running product min_level * ratio^n, one word per entry
  lcq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (pv_r),
    .waddr (pi_r),
    .wdata (new_w),
    .raddr (i_r),
    .rdata (rd_data)
  );

  // Multiply one word of the previous product by the ratio
  always_comb begin
    n_ext    = MEM_AW'(n_r);
    last_idx = n_ext + MEM_AW'(2);
    carry_in = (pi_r == '0) ? '0 : carry_r;
    if (n_r == IDX_W'(1)) begin
      if (pi_r == MEM_AW'(0)) begin
        old_w = min_level[WORD_W-1:0];
      end else if (pi_r == MEM_AW'(1)) begin
        old_w = WORD_W'(min_level >> WORD_W);
      end else begin
        old_w = '0;
      end
    end else begin
      old_w = (pi_r <= n_ext) ? rd_data : '0;
    end
    prod    = PROD_W'(old_w) * PROD_W'(level_ratio) + PROD_W'(carry_in);
    new_w   = prod[WORD_W-1:0];
    ovf     = |new_w;
    thr_val = THR_W'({hi_r, lo_r}) + THR_W'(sticky_r);
  end

  // Sequence the passes: one per threshold, stop once a threshold is out of range or all are built
  always_comb begin
    st_nxt     = st_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    pv_nxt     = 1'b0;
    pi_nxt     = pi_r;
    carry_nxt  = carry_r;
    sticky_nxt = sticky_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    nfin_nxt   = nfin_r;
    thr_we     = 1'b0;
    thr_wa     = n_r;
    thr_wd     = thr_val;

    // Sort each new word: below the window, window low, window high
    if (pv_r) begin
      carry_nxt = prod[PROD_W-1:WORD_W];
      if (pi_r < n_ext) begin
        sticky_nxt = sticky_r | ovf;
      end
      if (pi_r == n_ext) begin
        lo_nxt = new_w;
      end
      if (pi_r == n_ext + MEM_AW'(1)) begin
        hi_nxt = new_w;
      end
    end

    unique case (st_r)
      ST_IDLE: begin
      end
      ST_LOAD: begin
        thr_we     = 1'b1;
        thr_wa     = '0;
        thr_wd     = THR_W'(min_level);
        n_nxt      = IDX_W'(1);
        i_nxt      = '0;
        sticky_nxt = 1'b0;
        st_nxt     = ST_PASS;
      end
      ST_PASS: begin
        pv_nxt = 1'b1;
        pi_nxt = i_r;
        if (i_r == last_idx) begin
          st_nxt = ST_DONE;
        end else begin
          i_nxt = i_r + MEM_AW'(1);
        end
      end
      ST_DONE: begin
        if (ovf) begin
          nfin_nxt = LIM_W'(n_r);
          st_nxt   = ST_IDLE;
        end else begin
          thr_we = 1'b1;
          if (n_r == IDX_W'(MAX_LEVELS - 1)) begin
            nfin_nxt = LIM_W'(MAX_LEVELS);
            st_nxt   = ST_IDLE;
          end else begin
            n_nxt      = n_r + IDX_W'(1);
            i_nxt      = '0;
            sticky_nxt = 1'b0;
            st_nxt     = ST_PASS;
          end
        end
      end
    endcase

    if (restart) begin
      st_nxt = ST_LOAD;
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_LOAD;
      pv_r   <= 1'b0;
      nfin_r <= '0;
    end else begin
      st_r   <= st_nxt;
      pv_r   <= pv_nxt;
      nfin_r <= nfin_nxt;
    end
  end

  // Advance datapath registers
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    i_r      <= i_nxt;
    pi_r     <= pi_nxt;
    carry_r  <= carry_nxt;
    sticky_r <= sticky_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    if (thr_we) begin
      thr_r[thr_wa] <= thr_wd;
    end
  end

  assign thr       = thr_r;
  assign sts.busy  = (st_r != ST_IDLE);
  assign sts.nfin  = nfin_r;

endmodule

@@ sv/log_contour_level_quantizer.sv @@
// Contour level quantizer: config registers, threshold generator and sample pipeline.
//
//  port group   direction  handshake           words
//  in_*         input      start && !busy      in_sample, signed Q16.16
//  out_*        output     out_strobe, 1 cycle out_level, signed 8 bit
//  cfg_*        input      cfg_we, no wait     cfg_addr, cfg_data
//
// One sample enters every cycle while busy is low; its level appears on out_level with out_strobe.
// The four stages are magnitude, parallel compare against all thresholds, group count,
// and final sum with sign.
// After reset and after every accepted min_level or level_ratio write, busy stays high
// while the thresholds are rebuilt one 16-bit word per cycle.
// Reset is synchronous and active low. The receiver cannot stall; nothing is held back.
module log_contour_level_quantizer
  import lcq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_strobe,
  output logic signed [LEVEL_W-1:0]  out_level,
  input  logic                       cfg_we,
  input  logic [CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int GRP    = 8;
  localparam int NGRP   = (MAX_LEVELS + GRP - 1) / GRP;
  localparam int PAD_W  = NGRP * GRP;
  localparam int GC_W   = $clog2(GRP + 1);
  localparam logic signed [LEVEL_W-1:0] LVL_MAX_S = LEVEL_W'(MAX_LEVELS);

  // Configuration registers
  logic [MIN_W-1:0]   min_level_r;
  logic [RATIO_W-1:0] level_ratio_r;
  logic [COUNT_W-1:0] level_count_r;
  logic               signed_mode_r;
  logic               restart;

  // Threshold generator interface
  thr_t [MAX_LEVELS-1:0] thr;
  gen_sts_t              gen_sts;
  logic [LIM_W-1:0]      cnt_eff;
  logic [LIM_W-1:0]      lim;

  // Pipeline
  logic                  accept;
  logic                  neg_in;
  logic                  kill_in;
  logic [SAMPLE_W-1:0]   mag_in;
  logic                  v1_r, neg1_r, kill1_r;
  logic [SAMPLE_W-1:0]   mag1_r;
  logic [MAX_LEVELS-1:0] hit;
  logic                  v2_r, neg2_r;
  logic [MAX_LEVELS-1:0] hit2_r;
  logic [PAD_W-1:0]      hit_pad;
  logic [NGRP-1:0][GC_W-1:0] gcnt;
  logic                  v3_r, neg3_r;
  logic [NGRP-1:0][GC_W-1:0] gcnt3_r;
  logic [LIM_W-1:0]      sum;
  logic [LEVEL_W-1:0]    lvl_abs;
  logic [LEVEL_W-1:0]    lvl_out;
  logic                  out_strobe_r;
  logic [LEVEL_W-1:0]    out_level_r;

  // Drop writes of a zero minimum or a ratio too close to one
  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      if (cfg_addr == REG_MIN_LEVEL && cfg_data[MIN_W-1:0] != '0) begin
        restart = 1'b1;
      end
      if (cfg_addr == REG_LEVEL_RATIO &&
          cfg_data[RATIO_W-1:0] >= RATIO_W'(RATIO_MIN)) begin
        restart = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_level_r   <= MIN_LEVEL_RST;
      level_ratio_r <= LEVEL_RATIO_RST;
      level_count_r <= LEVEL_COUNT_RST;
      signed_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_LEVEL: begin
          if (cfg_data[MIN_W-1:0] != '0) begin
            min_level_r <= cfg_data[MIN_W-1:0];
          end
        end
        REG_LEVEL_RATIO: begin
          if (cfg_data[RATIO_W-1:0] >= RATIO_W'(RATIO_MIN)) begin
            level_ratio_r <= cfg_data[RATIO_W-1:0];
          end
        end
        REG_LEVEL_COUNT: begin
          level_count_r <= cfg_data[COUNT_W-1:0];
        end
        REG_SIGNED_MODE: begin
          signed_mode_r <= cfg_data[0];
        end
      endcase
    end
  end

  lcq_thr_gen u_thr_gen (
    .clk         (clk),
    .rst_n       (rst_n),
    .restart     (restart),
    .min_level   (min_level_r),
    .level_ratio (level_ratio_r),
    .thr         (thr),
    .sts         (gen_sts)
  );

  assign busy   = gen_sts.busy;
  assign accept = start && !busy;

  // Clamp the level count and cut off thresholds that are out of range
  always_comb begin
    cnt_eff = (level_count_r > COUNT_W'(MAX_LEVELS)) ? LIM_W'(MAX_LEVELS)
                                                     : LIM_W'(level_count_r);
    lim     = (cnt_eff < gen_sts.nfin) ? cnt_eff : gen_sts.nfin;
  end

  // Stage 1: take the magnitude, kill negatives in unsigned mode
  always_comb begin
    neg_in  = in_sample[SAMPLE_W-1];
    mag_in  = neg_in ? (SAMPLE_W'(0) - $unsigned(in_sample)) : $unsigned(in_sample);
    kill_in = neg_in && !signed_mode_r;
  end

  // Stage 2: compare the magnitude against every threshold
  always_comb begin
    for (int j = 0; j < MAX_LEVELS; j++) begin
      hit[j] = ({1'b0, mag1_r} >= thr[j]) && (LIM_W'(j) < lim) && !kill1_r;
    end
  end

  // Stage 3: count hits in groups of eight
  always_comb begin
    hit_pad = PAD_W'(hit2_r);
    for (int g = 0; g < NGRP; g++) begin
      gcnt[g] = '0;
      for (int b = 0; b < GRP; b++) begin
        gcnt[g] = gcnt[g] + GC_W'(hit_pad[g * GRP + b]);
      end
    end
  end

  // Stage 4: sum the groups and put the sign back
  always_comb begin
    sum = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum = sum + LIM_W'(gcnt3_r[g]);
    end
    lvl_abs = LEVEL_W'(sum);
    lvl_out = neg3_r ? (LEVEL_W'(0) - lvl_abs) : lvl_abs;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= accept;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      out_strobe_r <= v3_r;
    end
  end

  // Advance payload words
  always_ff @(posedge clk) begin
    mag1_r      <= mag_in;
    neg1_r      <= neg_in;
    kill1_r     <= kill_in;
    hit2_r      <= hit;
    neg2_r      <= neg1_r;
    gcnt3_r     <= gcnt;
    neg3_r      <= neg2_r;
    out_level_r <= lvl_out;
  end

  assign out_strobe = out_strobe_r;
  assign out_level  = $signed(out_level_r);

  // Every accepted word comes out on out_strobe after passing v1_r, v2_r and v3_r
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_strobe)
    else $error("accepted word did not come out after four cycles");

  // A negative sample in unsigned mode gives level zero
  a_kill: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && kill1_r) |-> ##3 (out_level == '0))
    else $error("killed sample gave a nonzero level");

  // Hits form a run from the lowest threshold up
  a_therm: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> ((hit2_r & (hit2_r + 1'b1)) == '0))
    else $error("threshold hits are not contiguous");

  // Level stays within the level range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_level <= LVL_MAX_S && out_level >= -LVL_MAX_S))
    else $error("level out of range");

  // Rejected writes never reach the minimum or ratio registers
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (min_level_r != '0) && (level_ratio_r >= RATIO_W'(RATIO_MIN)))
    else $error("minimum or ratio register holds a rejected value");

endmodule
